### rtl/sec_pkg.sv
`timescale 1ns / 1ps
// sec_pkg: shared types and constants for the seeded chunk entity generator
// word layouts, configuration bundle, register indexes, hash and generator constants
// no dependencies

package sec_pkg;

    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;

    // splitmix64 finalizer constants
    localparam logic [63:0] MIX_GOLDEN = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] MIX_C1     = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] MIX_C2     = 64'h94D049BB133111EB;

    // xorshift64 state after reset
    localparam logic [63:0] RNG_RESET  = 64'hA3C59AC3F0E1D2B5;

    // register reset values
    localparam logic [31:0] SEED_RESET     = 32'd1;
    localparam logic [13:0] ENTITIES_RESET = 14'd0;
    localparam logic [8:0]  LAYERS_RESET   = 9'd5;
    localparam logic [6:0]  TEXTURES_RESET = 7'd1;
    localparam logic [23:0] MAX_POS_RESET  = 24'd14336;

    // saturation limits
    localparam logic [13:0] MAX_ENTITIES = 14'd8192;
    localparam logic [8:0]  MAX_LAYERS   = 9'd256;
    localparam logic [6:0]  MAX_TEXTURES = 7'd64;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SEED     = 3'd0,
        REG_ENTITIES = 3'd1,
        REG_LAYERS   = 3'd2,
        REG_TEXTURES = 3'd3,
        REG_MAX_POS  = 3'd4
    } reg_index_t;

    typedef struct packed {
        logic               first_of_chunk;
        logic signed [31:0] chunk_x;
        logic signed [31:0] chunk_y;
    } req_word_t;

    typedef struct packed {
        logic        entity_valid;
        logic [23:0] pos_x;
        logic [23:0] pos_y;
        logic [7:0]  layer_index;
        logic [5:0]  texture_index;
        logic        rect_large;
        logic        last_entity;
    } rsp_word_t;

    typedef struct packed {
        logic [31:0] seed;
        logic [13:0] entities_per_chunk;
        logic [8:0]  z_layers;
        logic [6:0]  texture_count;
        logic [23:0] max_pos;
    } cfg_t;

    // handshake between the sequencer and the output stage
    typedef struct packed {
        logic      done;
        rsp_word_t result;
    } core_status_t;

endpackage

### rtl/sec_mul.sv
`timescale 1ns / 1ps
// sec_mul: shared 32x32 unsigned multiplier with a registered product
// depends on nothing; used by sec_core for hash and range products

module sec_mul
(
    input  logic        clk,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [63:0] product
);

    logic [63:0] product_reg;

    always_ff @(posedge clk)
    begin
        product_reg <= {32'b0, a} * {32'b0, b};
    end

    assign product = product_reg;

endmodule

### rtl/sec_core.sv
`timescale 1ns / 1ps
// sec_core: sequencer and datapath for reseeding and entity draws
// depends on sec_pkg and sec_mul (one shared multiplier for all products)

module sec_core
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  sec_pkg::cfg_t        cfg,
    input  logic                 start,
    input  sec_pkg::req_word_t   req,
    input  logic                 take,
    output logic                 idle,
    output sec_pkg::core_status_t status
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_ADD  = 5'b00010,
        ST_MUL  = 5'b00100,
        ST_DRAW = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    logic [1:0]         k_reg, k_next;       // partial product step
    logic [1:0]         m_reg, m_next;       // which hash multiply
    logic [2:0]         d_reg, d_next;       // which draw
    logic [63:0]        rng_reg, rng_next;
    logic [13:0]        count_reg, count_next;
    logic [63:0]        v_reg, v_next;
    logic [63:0]        acc_reg, acc_next;
    sec_pkg::rsp_word_t res_reg, res_next;

    logic [31:0] mul_a, mul_b;
    logic [63:0] product;

    logic [13:0] total;
    logic [8:0]  layers;
    logic [6:0]  textures;
    logic        gen_ok;
    logic [63:0] mix_k;
    logic [63:0] add_sum;
    logic [31:0] acc_hi_sum;
    logic [63:0] mul_sum;
    logic [63:0] mixed;
    logic [63:0] rng_step;
    logic [31:0] word;
    logic [13:0] count_inc;

    function automatic logic [63:0] xorshift(input logic [63:0] s);
        logic [63:0] t;
        t = s ^ (s << 13);
        t = t ^ (t >> 7);
        t = t ^ (t << 17);
        return t;
    endfunction

    sec_mul u_mul
    (
        .clk     (clk),
        .a       (mul_a),
        .b       (mul_b),
        .product (product)
    );

    // effective configuration
    assign total    = (cfg.entities_per_chunk > sec_pkg::MAX_ENTITIES) ?
                      sec_pkg::MAX_ENTITIES : cfg.entities_per_chunk;
    assign layers   = (cfg.z_layers == 9'd0) ? 9'd1 :
                      ((cfg.z_layers > sec_pkg::MAX_LAYERS) ? sec_pkg::MAX_LAYERS : cfg.z_layers);
    assign textures = (cfg.texture_count > sec_pkg::MAX_TEXTURES) ?
                      sec_pkg::MAX_TEXTURES : cfg.texture_count;
    assign gen_ok   = (total != 14'd0) && (textures != 7'd0) && (count_reg < total);

    assign mix_k      = m_reg[0] ? sec_pkg::MIX_C2 : sec_pkg::MIX_C1;
    assign add_sum    = v_reg + sec_pkg::MIX_GOLDEN;
    assign acc_hi_sum = acc_reg[63:32] + product[31:0];
    assign mul_sum    = {acc_hi_sum, acc_reg[31:0]};
    assign mixed      = m_reg[0] ? (mul_sum ^ (mul_sum >> 31)) : (mul_sum ^ (mul_sum >> 27));
    assign rng_step   = xorshift(rng_reg);
    assign word       = rng_step[63:32];
    assign count_inc  = count_reg + 14'd1;

    // operand select for the shared multiplier
    always_comb
    begin
        mul_a = v_reg[31:0];
        mul_b = mix_k[31:0];
        if (state_reg == ST_MUL)
        begin
            case (k_reg)
                2'd1:
                begin
                    mul_a = v_reg[31:0];
                    mul_b = mix_k[63:32];
                end
                2'd2:
                begin
                    mul_a = v_reg[63:32];
                    mul_b = mix_k[31:0];
                end
                default:
                begin
                    mul_a = v_reg[31:0];
                    mul_b = mix_k[31:0];
                end
            endcase
        end
        else if (state_reg == ST_DRAW)
        begin
            mul_a = word;
            case (d_reg)
                3'd0, 3'd1: mul_b = {8'b0, cfg.max_pos};
                3'd2:       mul_b = {23'b0, layers};
                3'd3:       mul_b = {25'b0, textures};
                default:    mul_b = 32'd0;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        m_next     = m_reg;
        d_next     = d_reg;
        rng_next   = rng_reg;
        count_next = count_reg;
        v_next     = v_reg;
        acc_next   = acc_reg;
        res_next   = res_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (req.first_of_chunk)
                    begin
                        v_next     = {req.chunk_x, req.chunk_y};
                        count_next = 14'd0;
                        m_next     = 2'd0;
                        state_next = ST_ADD;
                    end
                    else if (gen_ok)
                    begin
                        d_next     = 3'd0;
                        state_next = ST_DRAW;
                    end
                    else
                    begin
                        res_next   = '0;
                        state_next = ST_DONE;
                    end
                end
            end
            ST_ADD:
            begin
                v_next     = add_sum ^ (add_sum >> 30);
                k_next     = 2'd0;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                k_next = k_reg + 2'd1;
                case (k_reg)
                    2'd1: acc_next = product;
                    2'd2: acc_next = mul_sum;
                    2'd3:
                    begin
                        case (m_reg)
                            2'd1:
                            begin
                                // second hash starts from seed xor coordinate hash
                                v_next     = mixed ^ {32'b0, cfg.seed};
                                m_next     = 2'd2;
                                state_next = ST_ADD;
                            end
                            2'd3:
                            begin
                                rng_next = mixed;
                                if (gen_ok)
                                begin
                                    d_next     = 3'd0;
                                    state_next = ST_DRAW;
                                end
                                else
                                begin
                                    res_next   = '0;
                                    state_next = ST_DONE;
                                end
                            end
                            default:
                            begin
                                v_next = mixed;
                                m_next = m_reg + 2'd1;
                            end
                        endcase
                    end
                    default: ;
                endcase
            end
            ST_DRAW:
            begin
                // product of the previous draw is ready this cycle
                rng_next = rng_step;
                d_next   = d_reg + 3'd1;
                case (d_reg)
                    3'd1: res_next.pos_x       = product[55:32];
                    3'd2: res_next.pos_y       = product[55:32];
                    3'd3: res_next.layer_index = product[39:32];
                    3'd4:
                    begin
                        res_next.texture_index = product[37:32];
                        res_next.rect_large    = word[0];
                        res_next.entity_valid  = 1'b1;
                        res_next.last_entity   = (count_inc == total);
                        count_next             = count_inc;
                        state_next             = ST_DONE;
                    end
                    default: ;
                endcase
            end
            ST_DONE:
            begin
                if (take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            k_reg     <= 2'd0;
            m_reg     <= 2'd0;
            d_reg     <= 3'd0;
            rng_reg   <= sec_pkg::RNG_RESET;
            count_reg <= 14'd0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            m_reg     <= m_next;
            d_reg     <= d_next;
            rng_reg   <= rng_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg   <= v_next;
        acc_reg <= acc_next;
        res_reg <= res_next;
    end

    assign idle          = (state_reg == ST_IDLE);
    assign status.done   = (state_reg == ST_DONE);
    assign status.result = res_reg;

endmodule

### rtl/seeded_chunk_entity_generator.sv
`timescale 1ns / 1ps
// seeded_chunk_entity_generator: top level with configuration registers and output stage
// depends on sec_pkg and sec_core
//
// usage
//   request channel (req_valid / req_ready / req): one word asks for one entity of a
//   chunk; first_of_chunk set reseeds the xorshift64 generator from the seed register
//   and the chunk coordinates through two splitmix64 finalizers and restarts the count
//   response channel (rsp_valid / rsp_ready / rsp): exactly one word per request;
//   entity_valid low with all fields zero past the entity count or when disabled
//   configuration: cfg_we writes cfg_data into register cfg_index at the clock edge;
//   the user must write only while the block is idle, the block does not enforce this; no read-back
// timing
//   one item at a time; req_ready is high only while the sequencer is idle and comes
//   back in the same cycle as rsp_valid rises, once the result enters the output register
//   request without reseed: five draws, four of them scaled through the shared 32x32
//   multiplier, then the output register load
//   request with reseed: two additions and four 64-bit hash multiplies, each built from
//   three partial products through the same multiplier, come first
//   empty word: no draws, only the reseed passes when it carries a reseed
// reset
//   rst_n clears registers to their reset values, the generator to its fixed start
//   state and the entity count to zero; no clearing pass
// stall
//   a finished word waits in the output register while rsp_ready is low; the block
//   still accepts the next request and holds its result until the register frees up

module seeded_chunk_entity_generator
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_ready,
    input  sec_pkg::req_word_t                  req,
    output logic                                rsp_valid,
    input  logic                                rsp_ready,
    output sec_pkg::rsp_word_t                  rsp,
    input  logic                                cfg_we,
    input  logic [sec_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [sec_pkg::CFG_DATA_W-1:0]      cfg_data
);

    sec_pkg::cfg_t         cfg_reg, cfg_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    sec_pkg::rsp_word_t    rsp_reg;
    sec_pkg::core_status_t status;
    logic                  core_idle;
    logic                  start;
    logic                  load;

    // configuration writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (sec_pkg::reg_index_t'(cfg_index))
                sec_pkg::REG_SEED:     cfg_next.seed               = cfg_data[31:0];
                sec_pkg::REG_ENTITIES: cfg_next.entities_per_chunk = cfg_data[13:0];
                sec_pkg::REG_LAYERS:   cfg_next.z_layers           = cfg_data[8:0];
                sec_pkg::REG_TEXTURES: cfg_next.texture_count      = cfg_data[6:0];
                sec_pkg::REG_MAX_POS:  cfg_next.max_pos            = cfg_data[23:0];
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.seed               <= sec_pkg::SEED_RESET;
            cfg_reg.entities_per_chunk <= sec_pkg::ENTITIES_RESET;
            cfg_reg.z_layers           <= sec_pkg::LAYERS_RESET;
            cfg_reg.texture_count      <= sec_pkg::TEXTURES_RESET;
            cfg_reg.max_pos            <= sec_pkg::MAX_POS_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // request side: only an idle sequencer takes a word
    assign req_ready = core_idle;
    assign start     = req_valid && core_idle;

    sec_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .start  (start),
        .req    (req),
        .take   (load),
        .idle   (core_idle),
        .status (status)
    );

    // output register; loads when empty or being drained this cycle
    assign load = status.done && (!rsp_valid_reg || rsp_ready);

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rsp_reg <= status.result;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

### rtl/sec_checker.sv
`timescale 1ns / 1ps
// sec_checker: port-level assertions for the seeded chunk entity generator
// depends on sec_pkg; bound to seeded_chunk_entity_generator below

module sec_checker
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  logic               req_ready,
    input  logic               rsp_valid,
    input  logic               rsp_ready,
    input  sec_pkg::rsp_word_t rsp
);

    // stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    // a word with no entity carries all-zero fields
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.entity_valid |-> rsp == '0)
        else $error("invalid response with nonzero fields");

    // last entity flag only on a produced entity
    a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.last_entity |-> rsp.entity_valid)
        else $error("last_entity without entity_valid");

    // one request at a time: ready drops after an accept
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while busy");

endmodule

bind seeded_chunk_entity_generator sec_checker u_sec_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

### verif/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for seeded_chunk_entity_generator, directed rows then random chunks
// depends on sec_pkg and the seeded_chunk_entity_generator rtl

module tb;

    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASES      = 8;
    localparam int PHASE_WORDS = 200;

    // one row of the directed stimulus: either a register write or a request word,
    // with a typed-in result where it is obvious (all-zero words)
    typedef struct {
        bit                  is_cfg;
        sec_pkg::reg_index_t idx;
        logic [31:0]         value;
        sec_pkg::req_word_t  word;
        bit                  typed;
        sec_pkg::rsp_word_t  typed_rsp;
    } stim_row_t;

    logic                          clk;
    logic                          rst_n;
    logic                          req_valid;
    logic                          req_ready;
    sec_pkg::req_word_t            req;
    logic                          rsp_valid;
    logic                          rsp_ready;
    sec_pkg::rsp_word_t            rsp;
    logic                          cfg_we;
    logic [sec_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [sec_pkg::CFG_DATA_W-1:0] cfg_data;

    // predictor copy of the block: registers, generator state, entities made so far
    sec_pkg::cfg_t shadow_cfg;
    logic [63:0]   gen_state;
    logic [13:0]   produced_count;

    sec_pkg::rsp_word_t pending_entities[$];
    stim_row_t          stim_rows[$];

    int          mismatch_count = 0;
    int          cycle_count;
    bit          idle_en;
    bit          hold_request = 1'b0;

    seeded_chunk_entity_generator u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ---------------------------------------------------------------- predictor

    // splitmix64 finalizer
    function automatic logic [63:0] mix64(input logic [63:0] v);
        logic [63:0] z;
        z = v + sec_pkg::MIX_GOLDEN;
        z = (z ^ (z >> 30)) * sec_pkg::MIX_C1;
        z = (z ^ (z >> 27)) * sec_pkg::MIX_C2;
        return z ^ (z >> 31);
    endfunction

    // one xorshift64 step, upper half is the drawn word
    function automatic logic [31:0] xorshift_word();
        logic [63:0] s;
        s = gen_state;
        s = s ^ (s << 13);
        s = s ^ (s >> 7);
        s = s ^ (s << 17);
        gen_state = s;
        return s[63:32];
    endfunction

    // multiply-high reduction of a fresh word to [0, bound)
    function automatic logic [31:0] scale_draw(input logic [31:0] bound);
        logic [63:0] p;
        p = {32'd0, xorshift_word()} * {32'd0, bound};
        return p[63:32];
    endfunction

    function automatic sec_pkg::rsp_word_t predict_entity(input sec_pkg::req_word_t w);
        sec_pkg::rsp_word_t r;
        logic [13:0]        total;
        logic [8:0]         layers;
        logic [6:0]         textures;
        logic [31:0]        draw;
        // saturate / clamp the registers the way the block uses them
        total = (shadow_cfg.entities_per_chunk > sec_pkg::MAX_ENTITIES)
                ? sec_pkg::MAX_ENTITIES : shadow_cfg.entities_per_chunk;
        if (shadow_cfg.z_layers == 9'd0)
            layers = 9'd1;
        else if (shadow_cfg.z_layers > sec_pkg::MAX_LAYERS)
            layers = sec_pkg::MAX_LAYERS;
        else
            layers = shadow_cfg.z_layers;
        textures = (shadow_cfg.texture_count > sec_pkg::MAX_TEXTURES)
                   ? sec_pkg::MAX_TEXTURES : shadow_cfg.texture_count;
        // reseed happens even when the word itself comes back empty
        if (w.first_of_chunk)
        begin
            gen_state      = mix64({32'd0, shadow_cfg.seed} ^ mix64({w.chunk_x, w.chunk_y}));
            produced_count = '0;
        end
        r = '0;
        if (total == 14'd0 || textures == 7'd0 || produced_count >= total)
            return r;
        r.entity_valid  = 1'b1;
        draw            = scale_draw({8'd0, shadow_cfg.max_pos});
        r.pos_x         = draw[23:0];
        draw            = scale_draw({8'd0, shadow_cfg.max_pos});
        r.pos_y         = draw[23:0];
        draw            = scale_draw({23'd0, layers});
        r.layer_index   = draw[7:0];
        draw            = scale_draw({25'd0, textures});
        r.texture_index = draw[5:0];
        draw            = xorshift_word();
        r.rect_large    = draw[0];
        produced_count  = produced_count + 14'd1;
        r.last_entity   = (produced_count == total);
        return r;
    endfunction

    // ---------------------------------------------------------------- drivers

    // register write at one clock edge; the shadow copy follows right away since
    // writes only happen while the block is idle
    task automatic write_reg(input sec_pkg::reg_index_t idx, input logic [31:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            sec_pkg::REG_SEED:     shadow_cfg.seed               = value;
            sec_pkg::REG_ENTITIES: shadow_cfg.entities_per_chunk = value[13:0];
            sec_pkg::REG_LAYERS:   shadow_cfg.z_layers           = value[8:0];
            sec_pkg::REG_TEXTURES: shadow_cfg.texture_count      = value[6:0];
            sec_pkg::REG_MAX_POS:  shadow_cfg.max_pos            = value[23:0];
            default:      ;
        endcase
    endtask

    // offer one request word; valid stays up across back-to-back words and only
    // drops for a random idle gap; prediction is taken at the accepting edge
    task automatic send_request(input sec_pkg::req_word_t w, input bit typed,
                                input sec_pkg::rsp_word_t typed_rsp);
        sec_pkg::rsp_word_t want;
        if (idle_en && $urandom_range(99) < 12)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= w;
        do
            @(posedge clk);
        while (!req_ready);
        want = predict_entity(w);
        pending_entities.insert(pending_entities.size(), typed ? typed_rsp : want);
    endtask

    // stop offering and wait for every expected word; each request yields exactly
    // one word, so a few spare cycles are enough to reach idle
    task automatic drain_entities();
        req_valid <= 1'b0;
        while (pending_entities.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic add_cfg(input sec_pkg::reg_index_t idx, input logic [31:0] value);
        stim_row_t row;
        row.is_cfg    = 1'b1;
        row.idx       = idx;
        row.value     = value;
        row.word      = '0;
        row.typed     = 1'b0;
        row.typed_rsp = '0;
        stim_rows.insert(stim_rows.size(), row);
    endtask

    task automatic add_req(input bit first, input logic [31:0] x, input logic [31:0] y,
                           input bit zero_result);
        stim_row_t row;
        row.is_cfg              = 1'b0;
        row.idx                 = sec_pkg::REG_SEED;
        row.value               = '0;
        row.word.first_of_chunk = first;
        row.word.chunk_x        = x;
        row.word.chunk_y        = y;
        row.typed               = zero_result;
        row.typed_rsp           = '0;
        stim_rows.insert(stim_rows.size(), row);
    endtask

    function automatic logic [31:0] rand_coord();
        // mostly full-range coordinates, sometimes ones near the origin
        if ($urandom_range(3) == 0)
            return 32'(int'($urandom_range(0, 8)) - 4);
        return $urandom;
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic check_field(input string name, input logic [23:0] want,
                               input logic [23:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, name, want, got);
        end
    endtask

    // compare every accepted response word with the oldest prediction
    always @(posedge clk)
    begin : check_rsp
        sec_pkg::rsp_word_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_entities.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: entity word with nothing expected: %h", $realtime, rsp);
            end
            else
            begin
                want = pending_entities.pop_front();
                check_field("entity_valid",  want.entity_valid,  rsp.entity_valid);
                check_field("pos_x",         want.pos_x,         rsp.pos_x);
                check_field("pos_y",         want.pos_y,         rsp.pos_y);
                check_field("layer_index",   want.layer_index,   rsp.layer_index);
                check_field("texture_index", want.texture_index, rsp.texture_index);
                check_field("rect_large",    want.rect_large,    rsp.rect_large);
                check_field("last_entity",   want.last_entity,   rsp.last_entity);
            end
        end
    end

    // response side: random back-pressure, plus one long hold-off on request;
    // the hold length is counted here so the sender keeps pushing meanwhile
    initial
    begin : receiver
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        rsp_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request && !hold_done)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ready <= 1'b0;
            end
            else
                rsp_ready <= !(idle_en && $urandom_range(99) < 12);
        end
    end

    // cycle limit: a hung handshake ends the run
    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("** seeded_chunk_entity_generator: FAILED **");
        $finish;
    end

    // ---------------------------------------------------------------- main sequence

    initial
    begin : main_seq
        sec_pkg::req_word_t w;
        logic [13:0]        eff_entities;
        int                 sent;
        int                 chunk_len;
        bit                 paused;

        rst_n          = 1'b0;
        req_valid      = 1'b0;
        req            = '0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        idle_en        = 1'b1;

        // predictor starts from the reset state
        shadow_cfg.seed               = sec_pkg::SEED_RESET;
        shadow_cfg.entities_per_chunk = sec_pkg::ENTITIES_RESET;
        shadow_cfg.z_layers           = sec_pkg::LAYERS_RESET;
        shadow_cfg.texture_count      = sec_pkg::TEXTURES_RESET;
        shadow_cfg.max_pos            = sec_pkg::MAX_POS_RESET;
        gen_state                     = sec_pkg::RNG_RESET;
        produced_count                = '0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed rows
        // out of reset the entity count register is zero, so nothing is produced
        add_req(1'b0, 32'h0000_0000, 32'h0000_0000, 1'b1);
        add_cfg(sec_pkg::REG_ENTITIES, 32'd2);
        // no reseed yet: draws come from the fixed start state
        add_req(1'b0, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
        add_req(1'b0, 32'h0000_0001, 32'h0000_0002, 1'b0);   // last of the chunk
        add_req(1'b0, 32'h0000_0000, 32'h0000_0000, 1'b1);   // past the count
        // zero seed, zero layers (acts as one), full texture range, widest positions
        add_cfg(sec_pkg::REG_SEED, 32'd0);
        add_cfg(sec_pkg::REG_LAYERS, 32'd0);
        add_cfg(sec_pkg::REG_TEXTURES, 32'd64);
        add_cfg(sec_pkg::REG_MAX_POS, 32'h00FF_FFFF);
        add_cfg(sec_pkg::REG_ENTITIES, 32'd1);
        add_req(1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        add_req(1'b0, 32'h0000_0000, 32'h0000_0000, 1'b1);
        add_req(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        // texture count zero disables output, but the reseed still lands
        add_cfg(sec_pkg::REG_SEED, 32'hFFFF_FFFF);
        add_cfg(sec_pkg::REG_LAYERS, 32'd256);
        add_cfg(sec_pkg::REG_TEXTURES, 32'd0);
        add_cfg(sec_pkg::REG_MAX_POS, 32'd0);
        add_req(1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
        // continue from that reseed: zero position bound, layer count saturating
        add_cfg(sec_pkg::REG_TEXTURES, 32'd1);
        add_cfg(sec_pkg::REG_LAYERS, 32'd511);
        add_cfg(sec_pkg::REG_ENTITIES, 32'd3);
        add_req(1'b0, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
        add_req(1'b0, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
        add_req(1'b0, 32'h0000_0000, 32'h0000_0000, 1'b0);
        add_req(1'b0, 32'h0000_0000, 32'h0000_0000, 1'b1);
        // one-unit position bound, texture and entity counts above their limits
        add_cfg(sec_pkg::REG_MAX_POS, 32'd1);
        add_cfg(sec_pkg::REG_TEXTURES, 32'd127);
        add_cfg(sec_pkg::REG_ENTITIES, 32'd16383);
        add_req(1'b1, 32'h0000_0000, 32'h0000_0000, 1'b0);
        add_req(1'b0, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
        add_req(1'b1, 32'h1234_5678, 32'hEDCB_A987, 1'b0);
        add_cfg(sec_pkg::REG_ENTITIES, 32'd8192);
        add_cfg(sec_pkg::REG_LAYERS, 32'd1);
        add_cfg(sec_pkg::REG_MAX_POS, 32'h0080_0000);
        add_req(1'b1, 32'hFFFF_FFFE, 32'h0000_0001, 1'b0);
        add_req(1'b0, 32'h0000_0000, 32'h0000_0000, 1'b0);

        foreach (stim_rows[i])
        begin
            if (stim_rows[i].is_cfg)
            begin
                drain_entities();
                write_reg(stim_rows[i].idx, stim_rows[i].value);
            end
            else
                send_request(stim_rows[i].word, stim_rows[i].typed, stim_rows[i].typed_rsp);
        end
        drain_entities();

        // random phases: fresh settings each time, mostly well-formed chunks
        for (int phase = 0; phase < PHASES; phase++)
        begin
            write_reg(sec_pkg::REG_SEED, $urandom);
            case ($urandom_range(9))
                0:       write_reg(sec_pkg::REG_ENTITIES, 32'd0);
                1:       write_reg(sec_pkg::REG_ENTITIES, $urandom_range(8192, 16383));
                default: write_reg(sec_pkg::REG_ENTITIES, $urandom_range(1, 12));
            endcase
            case ($urandom_range(3))
                0:       write_reg(sec_pkg::REG_LAYERS, $urandom_range(0, 511));
                1:       write_reg(sec_pkg::REG_LAYERS, 32'd256);
                default: write_reg(sec_pkg::REG_LAYERS, $urandom_range(1, 8));
            endcase
            if ($urandom_range(3) == 0)
                write_reg(sec_pkg::REG_TEXTURES, $urandom_range(0, 127));
            else
                write_reg(sec_pkg::REG_TEXTURES, $urandom_range(1, 64));
            case ($urandom_range(3))
                0:       write_reg(sec_pkg::REG_MAX_POS, $urandom & 32'h00FF_FFFF);
                1:       write_reg(sec_pkg::REG_MAX_POS, 32'h00FF_FFFF);
                2:       write_reg(sec_pkg::REG_MAX_POS, 32'd14336);
                default: write_reg(sec_pkg::REG_MAX_POS, $urandom_range(0, 300));
            endcase

            // one phase runs with no idling on either side
            idle_en = (phase != 2);
            // one phase opens with a long receiver hold-off so the block backs up
            if (phase == 4)
                hold_request = 1'b1;

            eff_entities = (shadow_cfg.entities_per_chunk > sec_pkg::MAX_ENTITIES)
                           ? sec_pkg::MAX_ENTITIES : shadow_cfg.entities_per_chunk;
            sent   = 0;
            paused = 1'b0;
            while (sent < PHASE_WORDS)
            begin
                // sender stops mid-phase once and waits for everything to come back
                if (phase == 5 && !paused && sent >= PHASE_WORDS / 2)
                begin
                    drain_entities();
                    paused = 1'b1;
                end
                if ($urandom_range(99) < 85)
                begin
                    // a chunk: reseed word, then follow-ups with junk coordinates,
                    // now and then running past the count
                    if (eff_entities == 14'd0 || eff_entities > 14'd12)
                        chunk_len = $urandom_range(1, 16);
                    else
                        chunk_len = int'(eff_entities)
                                    + (($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0);
                    for (int k = 0; k < chunk_len; k++)
                    begin
                        w.first_of_chunk = (k == 0);
                        w.chunk_x        = rand_coord();
                        w.chunk_y        = rand_coord();
                        send_request(w, 1'b0, '0);
                        sent++;
                    end
                end
                else
                begin
                    // noise: random reseed bit and coordinates
                    repeat ($urandom_range(1, 3))
                    begin
                        w.first_of_chunk = 1'($urandom_range(1));
                        w.chunk_x        = $urandom;
                        w.chunk_y        = $urandom;
                        send_request(w, 1'b0, '0);
                        sent++;
                    end
                end
            end
            drain_entities();
        end

        idle_en = 1'b1;
        drain_entities();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && pending_entities.size() == 0)
            $display("** seeded_chunk_entity_generator: PASSED **");
        else
            $display("** seeded_chunk_entity_generator: FAILED **");
        $finish;
    end

endmodule
